@@ sv/square_voice_with_exponential_release_core_defines.svh @@
// Assertion macros shared by the voice checker.
`ifndef SQUARE_VOICE_WITH_EXPONENTIAL_RELEASE_CORE_DEFINES_SVH
`define SQUARE_VOICE_WITH_EXPONENTIAL_RELEASE_CORE_DEFINES_SVH

// Same-cycle or sequence property, sampled on the rising clock, off in reset.
`define SQV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off in reset.
`define SQV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sqv_pkg.sv @@
// Types, constants and the note frequency table of the square voice.
`default_nettype none
package sqv_pkg;

  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 25;
  localparam int unsigned LEVEL_W     = 15;
  localparam int unsigned SCALE_W     = 25;
  localparam int unsigned FREQ_W      = 24;
  localparam int unsigned RF_W        = 16;

  localparam logic [RF_W-1:0] REL_MUL  = 16'd32440;
  localparam logic [RF_W-1:0] REL_STOP = 16'd1638;
  localparam logic [RF_W-1:0] REL_ONE  = 16'd32768;
  localparam logic [RF_W-1:0] REL_RND  = 16'd16384;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd22906492;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_NOTE_ON  = 2'd1,
    REQ_NOTE_OFF = 2'd2,
    REQ_STOP     = 2'd3
  } sqv_req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_LEVEL    = 1'b0,
    REG_INCREMENT_SCALE = 1'b1
  } sqv_reg_e;

  // Release and sounding status of the voice.
  typedef struct packed {
    logic            sounding;
    logic [RF_W-1:0] release_factor;
  } sqv_voice_t;

  // Top octave (notes 120 to 131) in Hz, Q14.10.
  localparam logic [FREQ_W-1:0] TOP_OCTAVE [12] = '{
    24'd8572947,  24'd9082720,  24'd9622807,  24'd10195009,
    24'd10801236, 24'd11443511, 24'd12123977, 24'd12844906,
    24'd13608704, 24'd14417920, 24'd15275254, 24'd16183568
  };

  // Lower octaves are the top octave shifted right with rounding.
  // The octave is n/12, taken as (n*43)>>9, which is exact for 0 to 127.
  function automatic logic [FREQ_W-1:0] note_freq(input logic [6:0] n);
    logic [12:0]       prod;
    logic [3:0]        oct;
    logic [3:0]        k;
    logic [3:0]        s;
    logic [FREQ_W:0]   f;
    logic [FREQ_W:0]   rnd;
    prod = 13'(n) * 13'd43;
    oct  = prod[12:9];
    k    = 4'(n - 7'(oct) * 7'd12);
    s    = 4'd10 - oct;
    f    = (FREQ_W + 1)'(TOP_OCTAVE[k]);
    rnd  = (s == 4'd0) ? '0 : ((FREQ_W + 1)'(1) << (s - 4'd1));
    return FREQ_W'((f + rnd) >> s);
  endfunction

endpackage
`default_nettype wire

@@ sv/sqv_if.sv @@
// Handshake interfaces for the request, result and configuration channels.
`default_nettype none
interface sqv_in_if
  import sqv_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] note_number;

  modport source (output valid, output req_type, output note_number, input ready);
  modport sink (input valid, input req_type, input note_number, output ready);
endinterface

interface sqv_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          voice_active;

  modport source (output valid, output sample_value, output voice_active, input ready);
  modport sink (input valid, input sample_value, input voice_active, output ready);
endinterface

interface sqv_cfg_if
  import sqv_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/sqv_voice_calc.sv @@
// Next-state and sample logic of the voice for one request word.
`default_nettype none
module sqv_voice_calc
  import sqv_pkg::*;
#(
  parameter int unsigned PHASE_BITS  = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  sqv_req_e                      req_i,
  input  logic [6:0]                    note_i,
  input  logic [LEVEL_W-1:0]            level_i,
  input  logic [SCALE_W-1:0]            scale_i,
  input  sqv_voice_t                    voice_i,
  input  logic [PHASE_BITS-1:0]         phase_i,
  input  logic [PHASE_BITS-1:0]         step_i,
  output sqv_voice_t                    voice_o,
  output logic [PHASE_BITS-1:0]         phase_o,
  output logic [PHASE_BITS-1:0]         step_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned PROD_W = FREQ_W + SCALE_W;
  localparam int unsigned EXT_W  = SAMPLE_BITS + 16;
  localparam int unsigned LSH    = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
  localparam int unsigned RSH    = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

  logic [FREQ_W-1:0]      freq;
  logic [PROD_W-1:0]      step_prod;
  logic [PHASE_BITS-1:0]  step_new;
  logic [30:0]            rel_prod;
  logic [RF_W-1:0]        rf_next;
  logic [30:0]            lvl_prod;
  logic [LEVEL_W-1:0]     mag;
  logic [EXT_W-1:0]       mag_ext;
  logic [SAMPLE_BITS-1:0] mag_s;
  logic                   neg;

  assign freq      = note_freq(note_i);
  assign step_prod = PROD_W'(freq) * PROD_W'(scale_i);
  assign step_new  = PHASE_BITS'(step_prod >> 18);

  // Release decay by 0.99 in Q1.15 and the released level, both rounded.
  assign rel_prod = 31'(voice_i.release_factor) * 31'(REL_MUL) + 31'(REL_RND);
  assign rf_next  = rel_prod[30:15];
  assign lvl_prod = 31'(level_i) * 31'(voice_i.release_factor) + 31'(REL_RND);
  assign mag      = (voice_i.release_factor != '0) ? lvl_prod[29:15] : level_i;

  assign mag_ext = (EXT_W'(mag) << LSH) >> RSH;
  assign mag_s   = mag_ext[SAMPLE_BITS-1:0];
  assign neg     = phase_i[PHASE_BITS-1];

  always_comb begin
    voice_o  = voice_i;
    phase_o  = phase_i;
    step_o   = step_i;
    sample_o = '0;
    unique case (req_i)
      REQ_NOTE_ON: begin
        step_o                 = step_new;
        phase_o                = '0;
        voice_o.release_factor = '0;
        voice_o.sounding       = 1'b1;
      end
      REQ_NOTE_OFF: begin
        if (voice_i.sounding && (voice_i.release_factor == '0)) begin
          voice_o.release_factor = REL_ONE;
        end
      end
      REQ_STOP: begin
        voice_o.sounding       = 1'b0;
        voice_o.release_factor = '0;
        phase_o                = '0;
      end
      REQ_TICK: begin
        if (voice_i.sounding) begin
          sample_o = $signed(neg ? (~mag_s + 1'b1) : mag_s);
          phase_o  = phase_i + step_i;
          if (voice_i.release_factor != '0) begin
            voice_o.release_factor = rf_next;
            // The tick that ends the release still carries its sample.
            if (rf_next <= REL_STOP) begin
              voice_o.sounding       = 1'b0;
              voice_o.release_factor = '0;
              step_o                 = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/square_voice_with_exponential_release_core.sv @@
// Top level of the square voice: registers, handshakes and configuration.
//
//   Channel  Dir  Words carried
//   req_i    in   req_type, note_number
//   rsp_o    out  sample_value, voice_active (one per request word)
//   cfg_i    in   index, data (register write, always ready)
//
// A request word is registered on acceptance and evaluated once the output
// register is free or being read, when the result is written into it.
// One word per cycle is sustained while results are taken; the input and output
// registers each hold one word, so a stalled output still lets one more word in.
// Reset clears the voice state and returns the registers to their defaults.
`default_nettype none
module square_voice_with_exponential_release_core
  import sqv_pkg::*;
#(
  parameter int unsigned PHASE_BITS  = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  sqv_in_if.sink          req_i,
  sqv_out_if.source       rsp_o,
  sqv_cfg_if.sink         cfg_i
);

  logic [LEVEL_W-1:0]            level_q;
  logic [SCALE_W-1:0]            scale_q;

  logic                          in_vld_q;
  sqv_req_e                      in_req_q;
  logic [6:0]                    in_note_q;

  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_active_q;

  sqv_voice_t                    voice_q, voice_d;
  logic [PHASE_BITS-1:0]         phase_q, phase_d;
  logic [PHASE_BITS-1:0]         step_q, step_d;
  logic signed [SAMPLE_BITS-1:0] sample_d;

  logic                          advance;
  logic                          in_take;

  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign in_take     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.sample_value = out_sample_q;
  assign rsp_o.voice_active = out_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      scale_q <= SCALE_RESET;
    end else if (cfg_i.valid) begin
      unique case (sqv_reg_e'(cfg_i.index))
        REG_OUTPUT_LEVEL:    level_q <= cfg_i.data[LEVEL_W-1:0];
        REG_INCREMENT_SCALE: scale_q <= cfg_i.data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q  <= sqv_req_e'(req_i.req_type);
      in_note_q <= req_i.note_number;
    end
  end

  sqv_voice_calc #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_calc (
    .req_i    (in_req_q),
    .note_i   (in_note_q),
    .level_i  (level_q),
    .scale_i  (scale_q),
    .voice_i  (voice_q),
    .phase_i  (phase_q),
    .step_i   (step_q),
    .voice_o  (voice_d),
    .phase_o  (phase_d),
    .step_o   (step_d),
    .sample_o (sample_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q   <= '0;
      phase_q   <= '0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      voice_q   <= voice_d;
      phase_q   <= phase_d;
      step_q    <= step_d;
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sample_q <= sample_d;
      out_active_q <= voice_d.sounding;
    end
  end

endmodule
`default_nettype wire

@@ sv/sqv_checker.sv @@
// Port-level checks of the square voice, bound to its top level.
`default_nettype none
`include "square_voice_with_exponential_release_core_defines.svh"
module sqv_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_valid_i,
  input wire                   in_ready_i,
  input wire                   out_valid_i,
  input wire                   out_ready_i,
  input wire [SAMPLE_BITS-1:0] out_sample_i,
  input wire                   out_active_i
);

  // A held result word keeps its contents until it is taken.
  `SQV_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_sample_i) && $stable(out_active_i), "result word changed while stalled")

  // The request side only backs up when the result side is full and stalled.
  `SQV_ASSERT(a_backpressure, !in_ready_i |-> (out_valid_i && !out_ready_i), "request stalled without a stalled result")

  // A fresh result follows a taken request word through the input register and the output register.
  `SQV_ASSERT(a_latency, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2), "result without a matching request")

endmodule

bind square_voice_with_exponential_release_core sqv_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sqv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_sample_i (rsp_o.sample_value),
  .out_active_i (rsp_o.voice_active)
);
`default_nettype wire
